// File: rtl/core/hawt_pkg.sv
package hawt_pkg;

    localparam int MAX_HANDLES = 256;
    localparam int HANDLE_W    = 8;
    localparam int WORD_W      = 32;
    localparam int REC_W       = 3 * WORD_W;
    localparam int CNT_W       = $clog2(MAX_HANDLES + 1);

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_UPDATE = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_GET    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_INVALID = 2'd1,
        STATUS_FULL    = 2'd2
    } status_t;

    typedef struct packed {
        mode_t                 mode;
        logic [HANDLE_W-1:0]   handle_in;
        logic [WORD_W-1:0]     pos_x;
        logic [WORD_W-1:0]     pos_y;
        logic [WORD_W-1:0]     pos_z;
    } req_t;

    typedef struct packed {
        logic [HANDLE_W-1:0]   handle_out;
        logic [WORD_W-1:0]     read_x;
        logic [WORD_W-1:0]     read_y;
        logic [WORD_W-1:0]     read_z;
        status_t               status;
    } rsp_t;

endpackage

// File: rtl/core/handle_allocator_with_table.sv
// a request transfer registers the request and the record and free-stack reads; the exec
// state then does the read-modify-write and loads the response register, waiting while
// that register is full and not draining; no new request is taken until exec is done
// reset: rst_n clears the free and issued counts, the fsm and the response valid;
// record and stack memories are not cleared, entries are only used after being written
module handle_allocator_with_table (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  hawt_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output hawt_pkg::rsp_t  rsp
);

    // one-hot control: idle waits for a request, exec owns the memory read data
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // request latched at transfer, used during the exec cycle
    hawt_pkg::req_t req_reg;

    // allocation counters
    logic [hawt_pkg::CNT_W-1:0] free_count_reg, free_count_next;
    logic [hawt_pkg::CNT_W-1:0] issued_count_reg, issued_count_next;

    // response output register, decouples the sink from the core
    logic           rsp_valid_reg, rsp_valid_next;
    hawt_pkg::rsp_t rsp_reg, rsp_next;

    // record memory: x, y, z words per handle
    logic [hawt_pkg::REC_W-1:0]    rec_mem [hawt_pkg::MAX_HANDLES];
    logic [hawt_pkg::REC_W-1:0]    rec_rd_reg;
    logic                          rec_we;
    logic [hawt_pkg::HANDLE_W-1:0] rec_waddr;

    // free stack memory, lifo of released handles
    logic [hawt_pkg::HANDLE_W-1:0] stk_mem [hawt_pkg::MAX_HANDLES];
    logic [hawt_pkg::HANDLE_W-1:0] stk_rd_reg;
    logic                          stk_we;
    logic [hawt_pkg::CNT_W-1:0]    free_dec;

    logic req_xfer;
    logic exec_done;
    logic issued;

    assign req_ready = (state_reg == ST_IDLE);
    assign req_xfer  = req_valid && req_ready;

    // exec finishes once the output register is free or being drained
    assign exec_done = (state_reg == ST_EXEC) && (!rsp_valid_reg || rsp_ready);

    // top of stack address, only meaningful when the stack is not empty
    assign free_dec = free_count_reg - 1'b1;

    // a handle is live once issued; double removal is not tracked
    assign issued = ({1'b0, req_reg.handle_in} < issued_count_reg);

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // record memory: read on request transfer, written in the exec cycle
    always_ff @(posedge clk)
    begin
        if (rec_we)
        begin
            rec_mem[rec_waddr] <= {req_reg.pos_x, req_reg.pos_y, req_reg.pos_z};
        end
        if (req_xfer)
        begin
            rec_rd_reg <= rec_mem[req.handle_in];
        end
    end

    // free stack memory: pop address read on transfer, push in the exec cycle
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[free_count_reg[hawt_pkg::HANDLE_W-1:0]] <= req_reg.handle_in;
        end
        if (req_xfer)
        begin
            stk_rd_reg <= stk_mem[free_dec[hawt_pkg::HANDLE_W-1:0]];
        end
    end

    // request capture, payload only
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            req_reg <= req;
        end
    end

    // read-modify-write of counters and memories for the latched request
    always_comb
    begin
        state_next        = state_reg;
        free_count_next   = free_count_reg;
        issued_count_next = issued_count_reg;
        rsp_valid_next    = rsp_valid_reg;
        rsp_next          = rsp_reg;
        rec_we            = 1'b0;
        rec_waddr         = req_reg.handle_in;
        stk_we            = 1'b0;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_done)
                begin
                    state_next          = ST_IDLE;
                    rsp_valid_next      = 1'b1;
                    rsp_next.handle_out = req_reg.handle_in;
                    rsp_next.read_x     = '0;
                    rsp_next.read_y     = '0;
                    rsp_next.read_z     = '0;
                    rsp_next.status     = hawt_pkg::STATUS_OK;

                    case (req_reg.mode)
                        hawt_pkg::MODE_ADD:
                        begin
                            if (free_count_reg != '0)
                            begin
                                // reuse the most recently freed handle
                                free_count_next     = free_dec;
                                rsp_next.handle_out = stk_rd_reg;
                                rec_we              = 1'b1;
                                rec_waddr           = stk_rd_reg;
                            end
                            else if (issued_count_reg
                                     < hawt_pkg::CNT_W'(hawt_pkg::MAX_HANDLES))
                            begin
                                // fresh handle from the never-used range
                                issued_count_next   = issued_count_reg + 1'b1;
                                rsp_next.handle_out =
                                    issued_count_reg[hawt_pkg::HANDLE_W-1:0];
                                rec_we              = 1'b1;
                                rec_waddr           =
                                    issued_count_reg[hawt_pkg::HANDLE_W-1:0];
                            end
                            else
                            begin
                                rsp_next.handle_out = '0;
                                rsp_next.status     = hawt_pkg::STATUS_FULL;
                            end
                        end
                        hawt_pkg::MODE_UPDATE:
                        begin
                            if (issued)
                            begin
                                rec_we = 1'b1;
                            end
                            else
                            begin
                                rsp_next.status = hawt_pkg::STATUS_INVALID;
                            end
                        end
                        hawt_pkg::MODE_REMOVE:
                        begin
                            if (issued)
                            begin
                                // push dropped silently when the stack is full
                                if (free_count_reg
                                    < hawt_pkg::CNT_W'(hawt_pkg::MAX_HANDLES))
                                begin
                                    stk_we          = 1'b1;
                                    free_count_next = free_count_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                rsp_next.status = hawt_pkg::STATUS_INVALID;
                            end
                        end
                        hawt_pkg::MODE_GET:
                        begin
                            if (issued)
                            begin
                                rsp_next.read_x = rec_rd_reg[3*hawt_pkg::WORD_W-1:
                                                             2*hawt_pkg::WORD_W];
                                rsp_next.read_y = rec_rd_reg[2*hawt_pkg::WORD_W-1:
                                                             hawt_pkg::WORD_W];
                                rsp_next.read_z = rec_rd_reg[hawt_pkg::WORD_W-1:0];
                            end
                            else
                            begin
                                rsp_next.status = hawt_pkg::STATUS_INVALID;
                            end
                        end
                        default:
                        begin
                            rsp_next.status = hawt_pkg::STATUS_INVALID;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            free_count_reg   <= '0;
            issued_count_reg <= '0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            free_count_reg   <= free_count_next;
            issued_count_reg <= issued_count_next;
            rsp_valid_reg    <= rsp_valid_next;
        end
    end

    // response payload
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    // a transfer always leads into the exec cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer |=> (state_reg == ST_EXEC))
        else $error("request transfer did not enter exec");

    // counters never pass the table size
    assert property (@(posedge clk) disable iff (!rst_n)
        (free_count_reg <= hawt_pkg::CNT_W'(hawt_pkg::MAX_HANDLES)) &&
        (issued_count_reg <= hawt_pkg::CNT_W'(hawt_pkg::MAX_HANDLES)))
        else $error("allocation counter out of range");

    // counters only move when a request completes
    assert property (@(posedge clk) disable iff (!rst_n)
        !exec_done |=> ($stable(free_count_reg) && $stable(issued_count_reg)))
        else $error("counter changed outside exec");

    // full status carries handle zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (rsp_reg.status == hawt_pkg::STATUS_FULL))
            |-> (rsp_reg.handle_out == '0))
        else $error("full response with nonzero handle");

    // error responses return zero read words
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (rsp_reg.status != hawt_pkg::STATUS_OK))
            |-> ((rsp_reg.read_x == '0) && (rsp_reg.read_y == '0) &&
                 (rsp_reg.read_z == '0)))
        else $error("error response with nonzero read data");

endmodule
